[rtl/core/duff_pkg.sv]
// duff_pkg: shared types, constants and sequencer codes for the duffing rk4 integrator
// depends on nothing; used by rtl/core/duffing_rk4_integrator.sv
package duff_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 20;
  localparam int STEP_WIDTH      = 21;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
  localparam int RND_WIDTH       = PROD_WIDTH - FRAC_BITS;
  // weighted rk sum k1 + 2k2 + 2k3 + k4, exact, rounded up to whole nibbles
  localparam int SUM_WIDTH       = DATA_WIDTH + 4;
  localparam int DIV_STEPS       = SUM_WIDTH / 4;
  localparam int DIV_CNT_WIDTH   = $clog2(DIV_STEPS + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [PROD_WIDTH-1:0] ROUND_HALF =
    {{(PROD_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic [STEP_WIDTH-1:0] TIME_STEP_RESET       = STEP_WIDTH'(10486);
  localparam word_t                 DAMPING_RATIO_RESET   = DATA_WIDTH'(52429);
  localparam word_t                 CUBIC_STIFFNESS_RESET = DATA_WIDTH'(1048576);

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIME_STEP       = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DAMPING_RATIO   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CUBIC_STIFFNESS = 2'd2;

  // rk stages
  localparam logic [1:0] RK_STAGE_1 = 2'd0;
  localparam logic [1:0] RK_STAGE_2 = 2'd1;
  localparam logic [1:0] RK_STAGE_3 = 2'd2;
  localparam logic [1:0] RK_STAGE_4 = 2'd3;

  // steps within one rk stage
  localparam logic [3:0] STEP_DAMP    = 4'd0;
  localparam logic [3:0] STEP_SQUARE  = 4'd1;
  localparam logic [3:0] STEP_DOUBLE  = 4'd2;
  localparam logic [3:0] STEP_CUBE    = 4'd3;
  localparam logic [3:0] STEP_LINEAR  = 4'd4;
  localparam logic [3:0] STEP_STIFF   = 4'd5;
  localparam logic [3:0] STEP_ARG_POS = 4'd6;
  localparam logic [3:0] STEP_CUBIC   = 4'd7;
  localparam logic [3:0] STEP_VEL_INC = 4'd8;
  localparam logic [3:0] STEP_WAIT    = 4'd9;
  localparam logic [3:0] STEP_ARG_VEL = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAGE,
    ST_DIV,
    ST_FIN_POS,
    ST_FIN_VEL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    AD_NONE,
    AD_T,
    AD_ACC,
    AD_YA,
    AD_YB,
    AD_POS,
    AD_VEL
  } alu_dst_t;

  typedef enum logic [2:0] {
    MD_NONE,
    MD_DAMP,
    MD_SQ,
    MD_K,
    MD_CUBE,
    MD_EC,
    MD_L
  } mul_dst_t;

  typedef struct packed {
    word_t force_sample;
    logic  new_run;
  } item_t;

  typedef struct packed {
    word_t displacement;
    word_t speed;
    word_t disp_peak_high;
    word_t disp_peak_low;
    word_t speed_peak_high;
    word_t speed_peak_low;
  } result_t;

endpackage

[rtl/core/duffing_rk4_integrator.sv]
// duffing_rk4_integrator: one rk4 step of a damped duffing oscillator per request
// depends on duff_pkg (types, constants, sequencer codes)
//
//   channel   direction  payload             handshake
//   item      in         item_t              item_valid / item_ready
//   result    out        result_t            result_valid / result_ready
//   cfg       in         cfg_index, cfg_data cfg_valid / cfg_ready
//
// a request runs four rk stages, each stepping from STEP_DAMP through STEP_ARG_VEL
// on the one shared 32x32 multiplier and saturating adder, then a divide by six
// (a load step, then one nibble a cycle), two final adds and a load of the result
// register. a new request is accepted only once the previous one has left its done state.
// item_ready is high only in idle; a result waiting on result_ready does not block the
// next request, which only stalls at its own final cycle until the result is taken.
// rst is synchronous: control, configuration and state registers return to their reset
// values; cfg_ready is always high.
module duffing_rk4_integrator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  duff_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output duff_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [duff_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  duff_pkg::word_t                     cfg_data
);

  localparam int W  = duff_pkg::DATA_WIDTH;
  localparam int SW = duff_pkg::SUM_WIDTH;
  localparam int PW = duff_pkg::PROD_WIDTH;
  localparam int RW = duff_pkg::RND_WIDTH;

  // configuration
  logic [duff_pkg::STEP_WIDTH-1:0] time_step;
  duff_pkg::word_t                 damping_ratio;
  duff_pkg::word_t                 cubic_stiffness;

  // control
  duff_pkg::state_t   state, state_next;
  logic [3:0]         step;
  logic [1:0]         stage;
  logic [duff_pkg::DIV_CNT_WIDTH-1:0] div_cnt;
  duff_pkg::mul_dst_t mul_dst_q;

  // architectural state
  duff_pkg::word_t position, velocity;
  duff_pkg::word_t pos_max, pos_min, vel_max, vel_min;

  // working registers
  duff_pkg::word_t excitation, ya, yb, t, acc, damp, sq, cube, ec, k, l;
  logic signed [SW-1:0] ksum, lsum;
  logic [SW-1:0]        kdiv, ldiv;
  logic [2:0]           krem, lrem;
  logic                 kneg, lneg;
  logic signed [PW-1:0] prod_q;
  duff_pkg::result_t    result_q;

  // decoder outputs
  duff_pkg::word_t    alu_a, alu_b, alu_y, mul_a, mul_b, mul_y;
  logic               alu_sub;
  duff_pkg::alu_dst_t alu_dst;
  duff_pkg::mul_dst_t mul_dst;
  logic               acc_k, acc_l;

  duff_pkg::word_t      dt_word, kh, lh, qk, ql;
  logic signed [PW-1:0] mul_full, prod_rnd;
  logic                 weight2;
  logic [6:0]           kdig, ldig;

  function automatic duff_pkg::word_t sat_addsub(input duff_pkg::word_t a,
                                                 input duff_pkg::word_t b,
                                                 input logic sub);
    logic signed [W:0] s;
    s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
    if (s[W] != s[W-1]) begin
      return s[W] ? duff_pkg::WORD_MIN : duff_pkg::WORD_MAX;
    end
    return s[W-1:0];
  endfunction

  // halve, truncating toward zero
  function automatic duff_pkg::word_t half_tz(input duff_pkg::word_t v);
    duff_pkg::word_t h;
    h = v >>> 1;
    return h + duff_pkg::word_t'({{(W-1){1'b0}}, v[W-1] & v[0]});
  endfunction

  // one quotient digit of a divide by six: x < 96, returns {quotient, remainder}
  function automatic logic [6:0] div6_digit(input logic [6:0] x);
    logic [3:0] q;
    logic [6:0] r;
    q = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (x >= 7'(6 * j)) q = 4'(j);
    end
    r = x - ({3'b0, q} << 2) - ({3'b0, q} << 1);
    return {q, r[2:0]};
  endfunction

  function automatic duff_pkg::word_t signed_quot(input logic [SW-1:0] mag,
                                                  input logic neg);
    logic signed [SW:0] v;
    logic [SW-W+1:0]    top;
    v   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    top = v[SW:W-1];
    if (!((&top) || !(|top))) begin
      return v[SW] ? duff_pkg::WORD_MIN : duff_pkg::WORD_MAX;
    end
    return v[W-1:0];
  endfunction

  assign item_ready = (state == duff_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign result     = result_q;

  assign dt_word = duff_pkg::word_t'({{(W-duff_pkg::STEP_WIDTH){1'b0}}, time_step});
  assign kh      = (stage == duff_pkg::RK_STAGE_3) ? k : half_tz(k);
  assign lh      = (stage == duff_pkg::RK_STAGE_3) ? l : half_tz(l);
  assign weight2 = (stage == duff_pkg::RK_STAGE_2) || (stage == duff_pkg::RK_STAGE_3);
  assign qk      = signed_quot(kdiv, kneg);
  assign ql      = signed_quot(ldiv, lneg);
  assign kdig    = div6_digit({krem, kdiv[SW-1 -: 4]});
  assign ldig    = div6_digit({lrem, ldiv[SW-1 -: 4]});

  // shared units
  assign alu_y    = sat_addsub(alu_a, alu_b, alu_sub);
  assign mul_full = mul_a * mul_b;

  // round to nearest, ties away from zero, then saturate
  always_comb begin
    logic [RW-W:0] top;
    prod_rnd = prod_q + $signed(prod_q[PW-1] ? (duff_pkg::ROUND_HALF - PW'(1))
                                             : duff_pkg::ROUND_HALF);
    top = prod_rnd[PW-1:duff_pkg::FRAC_BITS+W-1];
    if ((&top) || !(|top)) begin
      mul_y = prod_rnd[duff_pkg::FRAC_BITS+W-1:duff_pkg::FRAC_BITS];
    end else begin
      mul_y = prod_rnd[PW-1] ? duff_pkg::WORD_MIN : duff_pkg::WORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= duff_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = acc;
    alu_b      = ya;
    alu_sub    = 1'b0;
    alu_dst    = duff_pkg::AD_NONE;
    mul_a      = yb;
    mul_b      = yb;
    mul_dst    = duff_pkg::MD_NONE;
    acc_k      = 1'b0;
    acc_l      = 1'b0;
    unique case (state)
      duff_pkg::ST_IDLE: begin
        if (item_valid) state_next = duff_pkg::ST_STAGE;
      end
      duff_pkg::ST_STAGE: begin
        unique case (step)
          duff_pkg::STEP_DAMP: begin
            mul_a   = damping_ratio;
            mul_b   = yb;
            mul_dst = duff_pkg::MD_DAMP;
          end
          duff_pkg::STEP_SQUARE: begin
            mul_a   = ya;
            mul_b   = ya;
            mul_dst = duff_pkg::MD_SQ;
          end
          duff_pkg::STEP_DOUBLE: begin
            mul_a   = dt_word;
            mul_b   = yb;
            mul_dst = duff_pkg::MD_K;
            alu_a   = damp;
            alu_b   = damp;
            alu_dst = duff_pkg::AD_T;
          end
          duff_pkg::STEP_CUBE: begin
            mul_a   = sq;
            mul_b   = ya;
            mul_dst = duff_pkg::MD_CUBE;
            alu_a   = excitation;
            alu_b   = t;
            alu_sub = 1'b1;
            alu_dst = duff_pkg::AD_ACC;
          end
          duff_pkg::STEP_LINEAR: begin
            alu_a   = acc;
            alu_b   = ya;
            alu_sub = 1'b1;
            alu_dst = duff_pkg::AD_ACC;
            acc_k   = 1'b1;
          end
          duff_pkg::STEP_STIFF: begin
            mul_a   = cubic_stiffness;
            mul_b   = cube;
            mul_dst = duff_pkg::MD_EC;
          end
          duff_pkg::STEP_ARG_POS: begin
            alu_a   = position;
            alu_b   = kh;
            alu_dst = duff_pkg::AD_YA;
          end
          duff_pkg::STEP_CUBIC: begin
            alu_a   = acc;
            alu_b   = ec;
            alu_sub = 1'b1;
            alu_dst = duff_pkg::AD_ACC;
          end
          duff_pkg::STEP_VEL_INC: begin
            mul_a   = dt_word;
            mul_b   = acc;
            mul_dst = duff_pkg::MD_L;
          end
          duff_pkg::STEP_WAIT: begin
          end
          duff_pkg::STEP_ARG_VEL: begin
            alu_a   = velocity;
            alu_b   = lh;
            alu_dst = duff_pkg::AD_YB;
            acc_l   = 1'b1;
            if (stage == duff_pkg::RK_STAGE_4) state_next = duff_pkg::ST_DIV;
          end
          default: begin
          end
        endcase
      end
      duff_pkg::ST_DIV: begin
        if (div_cnt == duff_pkg::DIV_CNT_WIDTH'(duff_pkg::DIV_STEPS)) begin
          state_next = duff_pkg::ST_FIN_POS;
        end
      end
      duff_pkg::ST_FIN_POS: begin
        alu_a      = position;
        alu_b      = qk;
        alu_dst    = duff_pkg::AD_POS;
        state_next = duff_pkg::ST_FIN_VEL;
      end
      duff_pkg::ST_FIN_VEL: begin
        alu_a      = velocity;
        alu_b      = ql;
        alu_dst    = duff_pkg::AD_VEL;
        state_next = duff_pkg::ST_DONE;
      end
      duff_pkg::ST_DONE: begin
        if (!result_valid || result_ready) state_next = duff_pkg::ST_IDLE;
      end
      default: begin
        state_next = duff_pkg::ST_IDLE;
      end
    endcase
  end

  // control counters, configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= duff_pkg::TIME_STEP_RESET;
      damping_ratio   <= duff_pkg::DAMPING_RATIO_RESET;
      cubic_stiffness <= duff_pkg::CUBIC_STIFFNESS_RESET;
      step            <= duff_pkg::STEP_DAMP;
      stage           <= duff_pkg::RK_STAGE_1;
      div_cnt         <= '0;
      mul_dst_q       <= duff_pkg::MD_NONE;
      result_valid    <= 1'b0;
      position        <= '0;
      velocity        <= '0;
      pos_max         <= duff_pkg::WORD_MIN;
      pos_min         <= duff_pkg::WORD_MAX;
      vel_max         <= duff_pkg::WORD_MIN;
      vel_min         <= duff_pkg::WORD_MAX;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          duff_pkg::CFG_TIME_STEP:       time_step <= cfg_data[duff_pkg::STEP_WIDTH-1:0];
          duff_pkg::CFG_DAMPING_RATIO:   damping_ratio <= cfg_data;
          duff_pkg::CFG_CUBIC_STIFFNESS: cubic_stiffness <= cfg_data;
          default: begin
          end
        endcase
      end

      mul_dst_q <= mul_dst;

      if (item_valid && item_ready) begin
        step    <= duff_pkg::STEP_DAMP;
        stage   <= duff_pkg::RK_STAGE_1;
        div_cnt <= '0;
        if (item.new_run) begin
          position <= '0;
          velocity <= '0;
        end
      end

      if (state == duff_pkg::ST_STAGE) begin
        if (step == duff_pkg::STEP_ARG_VEL) begin
          step  <= duff_pkg::STEP_DAMP;
          stage <= stage + 2'd1;
        end else begin
          step <= step + 4'd1;
        end
      end

      if (state == duff_pkg::ST_DIV) div_cnt <= div_cnt + duff_pkg::DIV_CNT_WIDTH'(1);

      if (alu_dst == duff_pkg::AD_POS) position <= alu_y;
      if (alu_dst == duff_pkg::AD_VEL) velocity <= alu_y;

      if ((state == duff_pkg::ST_DONE) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
        if (position > pos_max) pos_max <= position;
        if (position < pos_min) pos_min <= position;
        if (velocity > vel_max) vel_max <= velocity;
        if (velocity < vel_min) vel_min <= velocity;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_q <= mul_full;

    if (item_valid && item_ready) begin
      excitation <= item.force_sample;
      ya         <= item.new_run ? '0 : position;
      yb         <= item.new_run ? '0 : velocity;
      ksum       <= '0;
      lsum       <= '0;
    end

    unique case (alu_dst)
      duff_pkg::AD_T:   t   <= alu_y;
      duff_pkg::AD_ACC: acc <= alu_y;
      duff_pkg::AD_YA:  ya  <= alu_y;
      duff_pkg::AD_YB:  yb  <= alu_y;
      default: begin
      end
    endcase

    unique case (mul_dst_q)
      duff_pkg::MD_DAMP: damp <= mul_y;
      duff_pkg::MD_SQ:   sq   <= mul_y;
      duff_pkg::MD_K:    k    <= mul_y;
      duff_pkg::MD_CUBE: cube <= mul_y;
      duff_pkg::MD_EC:   ec   <= mul_y;
      duff_pkg::MD_L:    l    <= mul_y;
      default: begin
      end
    endcase

    // exact weighted sums of the stage increments
    if (acc_k) ksum <= ksum + (weight2 ? (SW'(k) <<< 1) : SW'(k));
    if (acc_l) lsum <= lsum + (weight2 ? (SW'(l) <<< 1) : SW'(l));

    // divide by six on magnitudes, one nibble a cycle, quotient shifts in from the bottom
    if (state == duff_pkg::ST_DIV) begin
      if (div_cnt == '0) begin
        kneg <= ksum[SW-1];
        lneg <= lsum[SW-1];
        kdiv <= ksum[SW-1] ? SW'(-ksum) : SW'(ksum);
        ldiv <= lsum[SW-1] ? SW'(-lsum) : SW'(lsum);
        krem <= 3'd0;
        lrem <= 3'd0;
      end else begin
        kdiv <= {kdiv[SW-5:0], kdig[6:3]};
        ldiv <= {ldiv[SW-5:0], ldig[6:3]};
        krem <= kdig[2:0];
        lrem <= ldig[2:0];
      end
    end

    if ((state == duff_pkg::ST_DONE) && (!result_valid || result_ready)) begin
      result_q.displacement    <= position;
      result_q.speed           <= velocity;
      result_q.disp_peak_high  <= (position > pos_max) ? position : pos_max;
      result_q.disp_peak_low   <= (position < pos_min) ? position : pos_min;
      result_q.speed_peak_high <= (velocity > vel_max) ? velocity : vel_max;
      result_q.speed_peak_low  <= (velocity < vel_min) ? velocity : vel_min;
    end
  end

endmodule

[sim/duffing_rk4_integrator_tb.sv]
// duffing_rk4_integrator_tb: self-checking bench for the duffing rk4 integrator
// depends on duff_pkg and duffing_rk4_integrator; a fixed-point step model predicts
// every result, which is checked field by field against the result channel
module duffing_rk4_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = longint'(duff_pkg::WORD_MAX);
  localparam longint SAT_LO = longint'(duff_pkg::WORD_MIN);
  localparam logic [duff_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES = 14;
  localparam int REQUESTS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  class oscillator_tracker;
    longint dt_q, zeta_q, eps_q;
    longint pos_q, vel_q, pos_top, pos_bottom, vel_top, vel_bottom;
    duff_pkg::result_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;
    string labels[6];

    function new();
      dt_q = longint'(duff_pkg::TIME_STEP_RESET);
      zeta_q = longint'(duff_pkg::DAMPING_RATIO_RESET);
      eps_q = longint'(duff_pkg::CUBIC_STIFFNESS_RESET);
      pos_q = 0;
      vel_q = 0;
      pos_top = SAT_LO;
      pos_bottom = SAT_HI;
      vel_top = SAT_LO;
      vel_bottom = SAT_HI;
      errors = 0;
      results_seen = 0;
      labels[0] = "displacement";
      labels[1] = "speed";
      labels[2] = "disp_peak_high";
      labels[3] = "disp_peak_low";
      labels[4] = "speed_peak_high";
      labels[5] = "speed_peak_low";
    endfunction

    function longint clamp(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // q11.20 product, round half away from zero on the magnitude, then saturate
    function longint fx_mul(longint a, longint b);
      logic [63:0] ma, mb, rnd;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      rnd = (ma * mb + (64'd1 << (duff_pkg::FRAC_BITS - 1))) >> duff_pkg::FRAC_BITS;
      if (neg) return (rnd > 64'd2147483648) ? SAT_LO : -longint'(rnd);
      return (rnd > 64'd2147483647) ? SAT_HI : longint'(rnd);
    endfunction

    function longint accel(longint f, longint y1, longint y2);
      longint damp, cube, acc;
      damp = fx_mul(zeta_q, y2);
      cube = fx_mul(fx_mul(y1, y1), y1);
      acc = clamp(f - clamp(damp + damp));
      acc = clamp(acc - y1);
      return clamp(acc - fx_mul(eps_q, cube));
    endfunction

    function void write_register(logic [duff_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                 duff_pkg::word_t data);
      case (idx)
        duff_pkg::CFG_TIME_STEP: begin
          dt_q = longint'(data[duff_pkg::STEP_WIDTH-1:0]);
        end
        duff_pkg::CFG_DAMPING_RATIO: begin
          zeta_q = longint'(data);
        end
        duff_pkg::CFG_CUBIC_STIFFNESS: begin
          eps_q = longint'(data);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(duff_pkg::item_t req);
      longint f, y1, y2, k1, k2, k3, k4, l1, l2, l3, l4;
      duff_pkg::result_t r;
      f = longint'(req.force_sample);
      if (req.new_run) begin
        pos_q = 0;
        vel_q = 0;
      end
      y1 = pos_q;
      y2 = vel_q;
      k1 = fx_mul(dt_q, y2);
      l1 = fx_mul(dt_q, accel(f, y1, y2));
      k2 = fx_mul(dt_q, clamp(y2 + l1 / 2));
      l2 = fx_mul(dt_q, accel(f, clamp(y1 + k1 / 2), clamp(y2 + l1 / 2)));
      k3 = fx_mul(dt_q, clamp(y2 + l2 / 2));
      l3 = fx_mul(dt_q, accel(f, clamp(y1 + k2 / 2), clamp(y2 + l2 / 2)));
      k4 = fx_mul(dt_q, clamp(y2 + l3));
      l4 = fx_mul(dt_q, accel(f, clamp(y1 + k3), clamp(y2 + l3)));
      // weighted sums are exact in 64 bits, divide truncates toward zero
      pos_q = clamp(y1 + clamp((k1 + 2 * k2 + 2 * k3 + k4) / 6));
      vel_q = clamp(y2 + clamp((l1 + 2 * l2 + 2 * l3 + l4) / 6));
      if (pos_q > pos_top) pos_top = pos_q;
      if (pos_q < pos_bottom) pos_bottom = pos_q;
      if (vel_q > vel_top) vel_top = vel_q;
      if (vel_q < vel_bottom) vel_bottom = vel_q;
      r.displacement = duff_pkg::word_t'(pos_q);
      r.speed = duff_pkg::word_t'(vel_q);
      r.disp_peak_high = duff_pkg::word_t'(pos_top);
      r.disp_peak_low = duff_pkg::word_t'(pos_bottom);
      r.speed_peak_high = duff_pkg::word_t'(vel_top);
      r.speed_peak_low = duff_pkg::word_t'(vel_bottom);
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(duff_pkg::result_t got);
      duff_pkg::result_t want;
      logic [$bits(duff_pkg::result_t)-1:0] wb, gb;
      duff_pkg::word_t wf, gf;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
        return;
      end
      want = expected_q.pop_front();
      wb = want;
      gb = got;
      for (int i = 0; i < 6; i++) begin
        wf = wb[$bits(duff_pkg::result_t)-1-32*i -: 32];
        gf = gb[$bits(duff_pkg::result_t)-1-32*i -: 32];
        if (wf !== gf)
          report($sformatf("result %0d %s: expected %0d (%h), got %0d (%h)",
                           results_seen, labels[i], wf, wf, gf, gf));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_ready;
  duff_pkg::item_t item;
  logic result_valid;
  logic result_ready;
  duff_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [duff_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  duff_pkg::word_t cfg_data;

  oscillator_tracker tracker = new();
  bit steady = 1'b0;
  int unsigned quiet_cycles = 0;

  duffing_rk4_integrator DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("duffing_rk4_integrator regression: fail");
      $finish;
    end
  end

  // valid stays high after acceptance; the caller lowers it when the burst ends
  task automatic send_request(duff_pkg::word_t force_val, logic run);
    int gap;
    duff_pkg::item_t req;
    gap = steady ? 0 : $urandom_range(0, 19);
    req.force_sample = force_val;
    req.new_run = run;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= req;
    do @(posedge clk); while (!item_ready);
    tracker.note_request(req);
  endtask

  task automatic cfg_write(logic [duff_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           duff_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  task automatic apply_setting(duff_pkg::word_t dt_data, duff_pkg::word_t zeta,
                               duff_pkg::word_t eps);
    cfg_write(duff_pkg::CFG_TIME_STEP, dt_data);
    cfg_write(duff_pkg::CFG_DAMPING_RATIO, zeta);
    cfg_write(duff_pkg::CFG_CUBIC_STIFFNESS, eps);
    // out-of-range index must leave every register alone
    cfg_write(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // result side: ready either raised early or held off for a while once valid shows
  initial begin
    bit early;
    int stall;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      early = steady || ($urandom_range(0, 3) == 0);
      stall = $urandom_range(0, 19);
      if (!early) begin
        result_ready <= 1'b0;
        do @(posedge clk); while (!result_valid);
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      tracker.check_result(result);
    end
  end

  initial begin
    int v;
    int unsigned pick;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= duff_pkg::CFG_TIME_STEP;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed requests on the reset settings: field extremes and new-run handling
    send_request(32'sd0, 1'b1);
    repeat (3) send_request(32'sh0010_0000, 1'b0);
    send_request(duff_pkg::WORD_MAX, 1'b0);
    send_request(duff_pkg::WORD_MIN, 1'b0);
    send_request(-32'sd1, 1'b0);
    send_request(duff_pkg::WORD_MIN, 1'b1);
    repeat (2) send_request(duff_pkg::WORD_MIN, 1'b0);
    send_request(duff_pkg::WORD_MAX, 1'b1);
    send_request(duff_pkg::WORD_MAX, 1'b0);
    send_request(32'sd0, 1'b1);
    send_request(32'sd1, 1'b0);
    send_request(32'shAAAA_AAAA, 1'b0);
    send_request(32'sh5555_5555, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    item_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      while (tracker.pending() != 0) @(posedge clk);
      case (p)
        0: apply_setting($urandom | 32'h001F_FFFF, duff_pkg::WORD_MAX, duff_pkg::WORD_MIN);
        1: apply_setting($urandom & 32'hFFE0_0000, duff_pkg::WORD_MIN, duff_pkg::WORD_MAX);
        2: apply_setting(32'sh0010_0000, 32'sd0, 32'sd0);
        3: apply_setting(duff_pkg::word_t'(duff_pkg::TIME_STEP_RESET),
                         duff_pkg::DAMPING_RATIO_RESET,
                         duff_pkg::CUBIC_STIFFNESS_RESET);
        default: begin
          apply_setting(($urandom_range(0, 3) != 0) ? $urandom_range(0, 65536) : $urandom,
                        ($urandom_range(0, 3) != 0) ?
                          int'($urandom_range(0, 2097152)) - 1048576 : $urandom,
                        ($urandom_range(0, 3) != 0) ?
                          int'($urandom_range(0, 16777216)) - 8388608 : $urandom);
        end
      endcase
      steady = (p % 4 == 3);
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) v = int'($urandom_range(0, 16777216)) - 8388608;
        else if (pick < 15) v = int'($urandom_range(0, 536870912)) - 268435456;
        else if (pick < 18) v = int'($urandom);
        else v = (pick == 18) ? duff_pkg::WORD_MAX : duff_pkg::WORD_MIN;
        send_request(duff_pkg::word_t'(v), (n == 0) || ($urandom_range(0, 29) == 0));
      end
      item_valid <= 1'b0;
    end

    steady = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("duffing_rk4_integrator regression: pass");
    else
      $display("duffing_rk4_integrator regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/duff_pkg.sv
rtl/core/duffing_rk4_integrator.sv
sim/duffing_rk4_integrator_tb.sv
